@@ hw/rtl/dipsc_pkg.sv @@
package dipsc_pkg;

	localparam int SpeedW  = 24;
	localparam int ErrW    = 25;
	localparam int GainW   = 16;
	localparam int LimW    = 15;
	localparam int DriveW  = 16;
	localparam int TickW   = 32;
	localparam int CfgIdxW = 2;

	// EMA weights, Q0.16 (sum is exactly 1.0)
	localparam logic [15:0] EmaKeep = 16'd62259;
	localparam logic [15:0] EmaNew  = 16'd3277;

	// register map
	localparam logic [CfgIdxW-1:0] RegPropGain   = 2'd0;
	localparam logic [CfgIdxW-1:0] RegIntegGain  = 2'd1;
	localparam logic [CfgIdxW-1:0] RegDriveLimit = 2'd2;

	localparam logic [GainW-1:0] PropGainRst   = 16'd256;
	localparam logic [GainW-1:0] IntegGainRst  = 16'd26;
	localparam logic [LimW-1:0]  DriveLimitRst = 15'd10000;

	typedef struct packed {
		logic signed [SpeedW-1:0] left_target;
		logic signed [SpeedW-1:0] left_measured;
		logic signed [SpeedW-1:0] right_target;
		logic signed [SpeedW-1:0] right_measured;
	} dipsc_in_t;

	typedef struct packed {
		logic signed [DriveW-1:0] left_drive;
		logic signed [DriveW-1:0] right_drive;
		logic [SpeedW-1:0]        left_peak_error;
		logic [SpeedW-1:0]        left_mean_error;
		logic [SpeedW-1:0]        right_peak_error;
		logic [SpeedW-1:0]        right_mean_error;
		logic [TickW-1:0]         tick_count;
	} dipsc_out_t;

	typedef struct packed {
		logic [GainW-1:0] prop_gain;
		logic [GainW-1:0] integ_gain;
		logic [LimW-1:0]  drive_limit;
	} dipsc_gains_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic seed;
	} dipsc_lane_ctrl_t;

	typedef struct packed {
		logic signed [DriveW-1:0] drive;
		logic [SpeedW-1:0]        peak;
		logic [SpeedW-1:0]        mean;
	} dipsc_wheel_res_t;

endpackage

@@ hw/rtl/dipsc_lane.sv @@
// One wheel: stage 1 forms the error and both gain products,
// stage 2 sums, clamps and updates the loop state.
module dipsc_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dipsc_pkg::dipsc_lane_ctrl_t      ctrl,
	input  logic signed [23:0]               target,
	input  logic signed [23:0]               measured,
	input  dipsc_pkg::dipsc_gains_t          gains,
	output dipsc_pkg::dipsc_wheel_res_t      res
);

	// stage 1
	logic signed [24:0] err;
	logic signed [25:0] diff;
	logic signed [42:0] prod_p;
	logic signed [41:0] prod_i;
	logic [24:0]        mag_full;
	logic [23:0]        mag;

	logic signed [24:0] prev_err_q;
	logic signed [42:0] prod_p_s1;
	logic signed [41:0] prod_i_s1;
	logic [23:0]        mag_s1;
	logic               seed_s1;

	// stage 2
	logic signed [43:0] acc;
	logic signed [43:0] lim;
	logic signed [43:0] nlim;
	logic signed [43:0] acc_clamped;
	logic [40:0]        ema_sum;
	logic [23:0]        mean_next;
	logic [23:0]        trunc_out;

	logic signed [23:0] prev_out_q;
	logic [23:0]        peak_q;
	logic [23:0]        mean_q;

	assign err    = {measured[23], measured} - {target[23], target};
	assign diff   = {err[24], err} - {prev_err_q[24], prev_err_q};
	assign prod_p = $signed({1'b0, gains.prop_gain}) * diff;
	assign prod_i = $signed({1'b0, gains.integ_gain}) * err;

	assign mag_full = err[24] ? (~err + 25'd1) : err;
	// only -2^24 reaches bit 24; saturate it
	assign mag      = mag_full[24] ? 24'hFFFFFF : mag_full[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (ctrl.load_s1) begin
			prev_err_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			prod_p_s1 <= prod_p;
			prod_i_s1 <= prod_i;
			mag_s1    <= mag;
			seed_s1   <= ctrl.seed;
		end
	end

	// Q.16 sum, clamped to +/- limit
	assign acc  = {{12{prev_out_q[23]}}, prev_out_q, 8'b0}
	            + {prod_p_s1[42], prod_p_s1}
	            + {{2{prod_i_s1[41]}}, prod_i_s1};
	assign lim  = {13'b0, gains.drive_limit, 16'b0};
	assign nlim = -lim;

	always_comb begin
		if (acc > lim) begin
			acc_clamped = lim;
		end else if (acc < nlim) begin
			acc_clamped = nlim;
		end else begin
			acc_clamped = acc;
		end
	end

	assign ema_sum   = 41'(mean_q) * 41'(dipsc_pkg::EmaKeep)
	                 + 41'(mag_s1) * 41'(dipsc_pkg::EmaNew) + 41'd32768;
	assign mean_next = seed_s1 ? mag_s1 : ema_sum[39:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_out_q <= '0;
			peak_q     <= '0;
			mean_q     <= '0;
		end else if (ctrl.load_s2) begin
			prev_out_q <= acc_clamped[31:8];   // floor to Q.8
			if (mag_s1 > peak_q) begin
				peak_q <= mag_s1;
			end
			mean_q <= mean_next;
		end
	end

	// drive: integer part toward zero
	assign trunc_out = prev_out_q[23] ? (prev_out_q + 24'd255) : prev_out_q;
	assign res.drive = trunc_out[23:8];
	assign res.peak  = peak_q;
	assign res.mean  = mean_q;

endmodule

@@ hw/rtl/dipsc_merge.sv @@
// Joins both lanes and the tick number into the result register.
module dipsc_merge (
	input  logic                         clk,
	input  logic                         load,
	input  dipsc_pkg::dipsc_wheel_res_t  left,
	input  dipsc_pkg::dipsc_wheel_res_t  right,
	input  logic [31:0]                  tick_num,
	output dipsc_pkg::dipsc_out_t        result
);

	dipsc_pkg::dipsc_out_t result_q;

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.left_drive       <= left.drive;
			result_q.right_drive      <= right.drive;
			result_q.left_peak_error  <= left.peak;
			result_q.left_mean_error  <= left.mean;
			result_q.right_peak_error <= right.peak;
			result_q.right_mean_error <= right.mean;
			result_q.tick_count       <= tick_num;
		end
	end

	assign result = result_q;

endmodule

@@ hw/rtl/dual_incremental_pi_speed_control_unit.sv @@
// Channel   Handshake              Payload
// tick      tick_valid/tick_stall  tick (dipsc_in_t)
// result    result_valid/stall     result (dipsc_out_t)
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One tick per cycle sustained while the result channel is not stalled: the error loop
// closes in lane stage 1 and the output, peak and mean loops close in lane stage 2.
// After its tick transaction a result is registered in stage 1, stage 2 and the
// result register, in that order, before result_valid rises.
// Reset sets the gains to their defaults, clears all loop state and the tick counter.
// A stalled result holds; up to three tick transactions sit in the block before tick_stall rises.
module dual_incremental_pi_speed_control_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	output logic                   tick_stall,
	input  dipsc_pkg::dipsc_in_t   tick,
	output logic                   result_valid,
	input  logic                   result_stall,
	output dipsc_pkg::dipsc_out_t  result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);

	dipsc_pkg::dipsc_gains_t      gains_q;
	dipsc_pkg::dipsc_lane_ctrl_t  ctrl;
	dipsc_pkg::dipsc_wheel_res_t  left_res;
	dipsc_pkg::dipsc_wheel_res_t  right_res;

	logic        s1_v_q;
	logic        s2_v_q;
	logic        out_v_q;
	logic        out_free;
	logic        load_out;
	logic        s2_free;
	logic        load_s2;
	logic        s1_free;
	logic        accept;
	logic [31:0] ticks_q;
	logic [31:0] tick_s1;
	logic [31:0] tick_s2;

	// ---- handshake / stage occupancy ----
	assign out_free = !out_v_q || !result_stall;
	assign load_out = s2_v_q && out_free;
	assign s2_free  = !s2_v_q || load_out;
	assign load_s2  = s1_v_q && s2_free;
	assign s1_free  = !s1_v_q || load_s2;
	assign accept   = tick_valid && s1_free;

	assign tick_stall   = !s1_free;
	assign result_valid = out_v_q;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (load_s2) begin
				s1_v_q <= 1'b0;
			end
			if (load_s2) begin
				s2_v_q <= 1'b1;
			end else if (load_out) begin
				s2_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// ---- tick counter; the EMA is seeded when the count is zero ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
		end else if (accept) begin
			ticks_q <= ticks_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= ticks_q + 32'd1;
		end
		if (load_s2) begin
			tick_s2 <= tick_s1;
		end
	end

	assign ctrl.load_s1 = accept;
	assign ctrl.load_s2 = load_s2;
	assign ctrl.seed    = (ticks_q == 32'd0);

	// ---- configuration registers; unknown index is dropped ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop_gain   <= dipsc_pkg::PropGainRst;
			gains_q.integ_gain  <= dipsc_pkg::IntegGainRst;
			gains_q.drive_limit <= dipsc_pkg::DriveLimitRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dipsc_pkg::RegPropGain:   gains_q.prop_gain   <= cfg_data;
				dipsc_pkg::RegIntegGain:  gains_q.integ_gain  <= cfg_data;
				dipsc_pkg::RegDriveLimit: gains_q.drive_limit <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// ---- lanes: left and right wheel ----
	dipsc_lane u_lane_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.target   (tick.left_target),
		.measured (tick.left_measured),
		.gains    (gains_q),
		.res      (left_res)
	);

	dipsc_lane u_lane_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.target   (tick.right_target),
		.measured (tick.right_measured),
		.gains    (gains_q),
		.res      (right_res)
	);

	// ---- merge into the result register ----
	dipsc_merge u_merge (
		.clk      (clk),
		.load     (load_out),
		.left     (left_res),
		.right    (right_res),
		.tick_num (tick_s2),
		.result   (result)
	);

	// ---- assertions ----
	// EMA of values never above the peak cannot exceed the peak
	a_left_mean_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		left_res.mean <= left_res.peak)
		else $error("left mean error above peak");

	a_right_mean_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		right_res.mean <= right_res.peak)
		else $error("right mean error above peak");

	// delivered drive stays inside the clamp
	a_left_drive_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(result.left_drive) <= $signed({1'b0, gains_q.drive_limit})
			&& $signed(result.left_drive) >= -$signed({1'b0, gains_q.drive_limit})))
		else $error("left drive outside limit");

	a_right_drive_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(result.right_drive) <= $signed({1'b0, gains_q.drive_limit})
			&& $signed(result.right_drive) >= -$signed({1'b0, gains_q.drive_limit})))
		else $error("right drive outside limit");

endmodule
